// ----- hdl/mrw_pkg.sv -----
// ----------------------------------------------------------------------------
// mrw_pkg
// Shared types and constants of the Miller-Rabin witness round.
// ----------------------------------------------------------------------------
package mrw_pkg;

    localparam int WIDTH = 64;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [1:0] VERDICT_PRIME     = 2'd0;
    localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
    localparam logic [1:0] VERDICT_INVALID   = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_VALID,
        OP_REDUCE,
        OP_POW_MUL,
        OP_POW_SQR,
        OP_SQR
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic bad_input;
        logic scan_done;
        logic scan_hit;
        logic exp_zero;
        logic exp_odd;
        logic x_one;
        logic x_top;
        logic d_at_top;
    } status_t;

endpackage

// ----- hdl/miller_rabin_witness_round.sv -----
// ----------------------------------------------------------------------------
// miller_rabin_witness_round
// One Miller-Rabin round on a 64-bit odd candidate with a given witness.
// ----------------------------------------------------------------------------
// One transaction at a time. The witness reduction and every modular product
// run through a single bit-serial shift-add unit. A round is one reduction,
// a multiply for each one bit and a squaring for each bit of d, then up to
// r squarings, after the input checks.
module miller_rabin_witness_round
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [mrw_pkg::WIDTH-1:0] candidate,
    input  logic [mrw_pkg::WIDTH-1:0] odd_part,
    input  logic [mrw_pkg::WIDTH-1:0] witness,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                verdict
);

    mrw_pkg::cmd_t    cmd;
    mrw_pkg::status_t status;

    mrw_control u_control
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict),
        .cmd       (cmd),
        .status    (status)
    );

    mrw_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .candidate (candidate),
        .odd_part  (odd_part),
        .witness   (witness),
        .status    (status)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict != 2'd3)
        else $error("verdict code out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict))
        else $error("stalled result changed");

endmodule

// ----- hdl/mrw_datapath.sv -----
// ----------------------------------------------------------------------------
// mrw_datapath
// Operand registers and a bit-serial modular multiplier, one bit per cycle.
// ----------------------------------------------------------------------------
module mrw_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mrw_pkg::cmd_t             cmd,
    input  logic [mrw_pkg::WIDTH-1:0] candidate,
    input  logic [mrw_pkg::WIDTH-1:0] odd_part,
    input  logic [mrw_pkg::WIDTH-1:0] witness,
    output mrw_pkg::status_t          status
);

    logic [mrw_pkg::WIDTH-1:0] n_reg, d_reg, t_reg, e_reg, base_reg, x_reg;
    logic [mrw_pkg::WIDTH-1:0] acc_reg, mb_reg;
    logic [mrw_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic [mrw_pkg::WIDTH-1:0] top;
    logic [mrw_pkg::WIDTH-1:0] op_a, op_b;
    logic [mrw_pkg::WIDTH-1:0] dbl, acc_next;
    logic [mrw_pkg::WIDTH-1:0] gap;
    logic                      last;

    assign top  = n_reg - 1'b1;
    assign last = (cnt_reg == mrw_pkg::CNT_W'(mrw_pkg::WIDTH - 1));

    // operand selection per operation
    always_comb
    begin
        unique case (cmd.op)
            mrw_pkg::OP_REDUCE:  begin op_a = base_reg; op_b = base_reg; end
            mrw_pkg::OP_POW_MUL: begin op_a = x_reg;    op_b = base_reg; end
            mrw_pkg::OP_POW_SQR: begin op_a = base_reg; op_b = base_reg; end
            mrw_pkg::OP_SQR:     begin op_a = x_reg;    op_b = x_reg; end
            default:             begin op_a = x_reg;    op_b = x_reg; end
        endcase
    end

    // one step: acc = 2*acc (+ a) mod n, operands below n;
    // reduce: shift in the next witness bit and subtract n once
    always_comb
    begin
        logic [mrw_pkg::WIDTH-1:0] g2;
        logic [mrw_pkg::WIDTH:0]   rem;
        g2 = n_reg - acc_reg;
        rem = {acc_reg, mb_reg[mrw_pkg::WIDTH-1]};
        dbl = (acc_reg >= g2) ? acc_reg - g2 : acc_reg + acc_reg;
        gap = n_reg - op_a;
        if (cmd.op == mrw_pkg::OP_REDUCE)
            acc_next = (rem >= {1'b0, n_reg}) ? mrw_pkg::WIDTH'(rem - {1'b0, n_reg})
                                              : rem[mrw_pkg::WIDTH-1:0];
        else if (mb_reg[mrw_pkg::WIDTH-1])
            acc_next = (dbl >= gap) ? dbl - gap : dbl + op_a;
        else
            acc_next = dbl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.op == mrw_pkg::OP_REDUCE || cmd.op == mrw_pkg::OP_POW_MUL ||
                 cmd.op == mrw_pkg::OP_POW_SQR || cmd.op == mrw_pkg::OP_SQR)
        begin
            if (!busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (last)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
        else
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            mrw_pkg::OP_LOAD:
            begin
                n_reg    <= candidate;
                d_reg    <= odd_part;
                t_reg    <= odd_part;
                e_reg    <= odd_part;
                base_reg <= witness;
                x_reg    <= mrw_pkg::WIDTH'(1);
            end
            mrw_pkg::OP_VALID:
                if (t_reg < top && !t_reg[mrw_pkg::WIDTH-1])
                    t_reg <= {t_reg[mrw_pkg::WIDTH-2:0], 1'b0};
            mrw_pkg::OP_REDUCE, mrw_pkg::OP_POW_MUL, mrw_pkg::OP_POW_SQR,
            mrw_pkg::OP_SQR:
            begin
                if (!busy_reg)
                begin
                    acc_reg <= '0;
                    mb_reg  <= op_b;
                end
                else
                begin
                    acc_reg <= acc_next;
                    mb_reg  <= {mb_reg[mrw_pkg::WIDTH-2:0], 1'b0};
                    if (last)
                    begin
                        unique case (cmd.op)
                            mrw_pkg::OP_REDUCE:  base_reg <= acc_next;
                            mrw_pkg::OP_POW_MUL: x_reg    <= acc_next;
                            mrw_pkg::OP_POW_SQR:
                            begin
                                base_reg <= acc_next;
                                e_reg    <= e_reg >> 1;
                            end
                            default:
                            begin
                                x_reg <= acc_next;
                                d_reg <= {d_reg[mrw_pkg::WIDTH-2:0], 1'b0};
                            end
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    assign status.mul_done  = busy_reg && last;
    assign status.bad_input = (n_reg < mrw_pkg::WIDTH'(5)) || !d_reg[0];
    assign status.scan_done = !(t_reg < top && !t_reg[mrw_pkg::WIDTH-1]);
    assign status.scan_hit  = (t_reg == top);
    assign status.exp_zero  = (e_reg == '0);
    assign status.exp_odd   = e_reg[0];
    assign status.x_one     = (x_reg == mrw_pkg::WIDTH'(1));
    assign status.x_top     = (x_reg == top);
    assign status.d_at_top  = (d_reg == top);

endmodule

// ----- hdl/mrw_control.sv -----
// ----------------------------------------------------------------------------
// mrw_control
// Sequencer of the witness round: validate, exponentiate, square, decide.
// ----------------------------------------------------------------------------
module mrw_control
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       verdict,
    output mrw_pkg::cmd_t    cmd,
    input  mrw_pkg::status_t status
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_RED   = 4'd3;
    localparam logic [3:0] S_PTEST = 4'd4;
    localparam logic [3:0] S_PMUL  = 4'd5;
    localparam logic [3:0] S_PSQR  = 4'd6;
    localparam logic [3:0] S_FIRST = 4'd7;
    localparam logic [3:0] S_LOOP  = 4'd8;
    localparam logic [3:0] S_SQR   = 4'd9;
    localparam logic [3:0] S_TEST  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] verdict_reg, verdict_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign verdict   = verdict_reg;

    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        cmd.op       = mrw_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = mrw_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            S_CHECK:
                if (status.bad_input)
                begin
                    verdict_next = mrw_pkg::VERDICT_INVALID;
                    state_next   = S_OUT;
                end
                else
                    state_next = S_SCAN;
            S_SCAN:
            begin
                cmd.op = mrw_pkg::OP_VALID;
                if (status.scan_done)
                begin
                    if (status.scan_hit)
                        state_next = S_RED;
                    else
                    begin
                        verdict_next = mrw_pkg::VERDICT_INVALID;
                        state_next   = S_OUT;
                    end
                end
            end
            S_RED:
            begin
                cmd.op = mrw_pkg::OP_REDUCE;
                if (status.mul_done)
                    state_next = S_PTEST;
            end
            S_PTEST:
                if (status.exp_zero)
                    state_next = S_FIRST;
                else if (status.exp_odd)
                    state_next = S_PMUL;
                else
                    state_next = S_PSQR;
            S_PMUL:
            begin
                cmd.op = mrw_pkg::OP_POW_MUL;
                if (status.mul_done)
                    state_next = S_PSQR;
            end
            S_PSQR:
            begin
                cmd.op = mrw_pkg::OP_POW_SQR;
                if (status.mul_done)
                    state_next = S_PTEST;
            end
            S_FIRST:
                if (status.x_one || status.x_top)
                begin
                    verdict_next = mrw_pkg::VERDICT_PRIME;
                    state_next   = S_OUT;
                end
                else
                    state_next = S_LOOP;
            S_LOOP:
                if (status.d_at_top)
                begin
                    verdict_next = mrw_pkg::VERDICT_COMPOSITE;
                    state_next   = S_OUT;
                end
                else
                    state_next = S_SQR;
            S_SQR:
            begin
                cmd.op = mrw_pkg::OP_SQR;
                if (status.mul_done)
                    state_next = S_TEST;
            end
            S_TEST:
                if (status.x_one)
                begin
                    verdict_next = mrw_pkg::VERDICT_COMPOSITE;
                    state_next   = S_OUT;
                end
                else if (status.x_top)
                begin
                    verdict_next = mrw_pkg::VERDICT_PRIME;
                    state_next   = S_OUT;
                end
                else
                    state_next = S_LOOP;
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            verdict_reg <= mrw_pkg::VERDICT_PRIME;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule
